### hw/rtl/atr_pkg.sv
// Shared types and constants of the rotozoom texture mapper.
package atr_pkg;

   localparam int TEX_SIDE_BITS = 8;
   localparam int FRAC_BITS     = 17;
   localparam int ACC_W         = FRAC_BITS + TEX_SIDE_BITS;
   localparam int STEP_W        = 18;
   localparam int DIM_W         = 11;
   localparam int COLOR_W       = 24;
   localparam int ADDR_W        = 2 * TEX_SIDE_BITS;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = STEP_W;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [STEP_W-1:0] STEP_X_RESET      = STEP_W'(26214);
   localparam logic [STEP_W-1:0] STEP_Y_RESET      = STEP_W'(0);
   localparam logic [DIM_W-1:0]  LINE_WIDTH_RESET  = DIM_W'(800);
   localparam logic [DIM_W-1:0]  FRAME_LINES_RESET = DIM_W'(400);

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_X      = 2'd0,
      CSR_STEP_Y      = 2'd1,
      CSR_LINE_WIDTH  = 2'd2,
      CSR_FRAME_LINES = 2'd3
   } csr_index_type;

   // One queued operation: a texel write or a pixel lookup at addr = {row, column}
   typedef struct packed {
      logic                is_pixel;
      logic [ADDR_W-1:0]   addr;
      logic [COLOR_W-1:0]  color;
      logic                line_end;
      logic                frame_end;
   } queue_entry_type;

endpackage

### hw/rtl/atr_front.sv
// Front end: config registers, item classification, u/v stepping and raster counters.
module atr_front import atr_pkg::*; #(
   parameter int MAX_LINE_WIDTH  = 1024,
   parameter int MAX_FRAME_LINES = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    in_mode,
   input  logic [ADDR_W-1:0]       in_addr,
   input  logic [COLOR_W-1:0]      in_color,
   input  logic                    q_full,
   output logic                    q_push,
   output queue_entry_type         q_entry
);

   localparam int LW_CW = $clog2(MAX_LINE_WIDTH);
   localparam int FL_CW = $clog2(MAX_FRAME_LINES);
   localparam int LW_CMP_W = (LW_CW + 1 > DIM_W) ? LW_CW + 1 : DIM_W;
   localparam int FL_CMP_W = (FL_CW + 1 > DIM_W) ? FL_CW + 1 : DIM_W;

   logic [STEP_W-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [DIM_W-1:0]  line_width_ff, line_width_in, frame_lines_ff, frame_lines_in;
   logic [ACC_W-1:0]  acc_u_ff, acc_u_in, acc_v_ff, acc_v_in;
   logic [ACC_W-1:0]  start_u_ff, start_u_in, start_v_ff, start_v_in;
   logic [LW_CW-1:0]  col_cnt_ff, col_cnt_in;
   logic [FL_CW-1:0]  line_cnt_ff, line_cnt_in;

   logic [ACC_W-1:0]    sx_ext, sy_ext, sum_u, sum_v;
   logic [LW_CMP_W-1:0] width_raw, width_eff, last_col;
   logic [FL_CMP_W-1:0] lines_raw, lines_eff, last_line;
   logic                accept, tick, line_end, frame_end;
   logic [TEX_SIDE_BITS-1:0] col, row;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign tick     = accept && (in_mode == MODE_PIXEL);

   assign sx_ext = {{(ACC_W-STEP_W){step_x_ff[STEP_W-1]}}, step_x_ff};
   assign sy_ext = {{(ACC_W-STEP_W){step_y_ff[STEP_W-1]}}, step_y_ff};
   assign sum_u  = acc_u_ff + sx_ext;
   assign sum_v  = acc_v_ff + sy_ext;
   assign col    = sum_u[ACC_W-1:FRAC_BITS];
   assign row    = sum_v[ACC_W-1:FRAC_BITS];

   // zero reads as one, oversize saturates
   always_comb begin
      width_raw = {{(LW_CMP_W-DIM_W){1'b0}}, line_width_ff};
      if (width_raw == '0) begin
         width_eff = LW_CMP_W'(1);
      end else if (width_raw > LW_CMP_W'(MAX_LINE_WIDTH)) begin
         width_eff = LW_CMP_W'(MAX_LINE_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      lines_raw = {{(FL_CMP_W-DIM_W){1'b0}}, frame_lines_ff};
      if (lines_raw == '0) begin
         lines_eff = FL_CMP_W'(1);
      end else if (lines_raw > FL_CMP_W'(MAX_FRAME_LINES)) begin
         lines_eff = FL_CMP_W'(MAX_FRAME_LINES);
      end else begin
         lines_eff = lines_raw;
      end
      last_col  = width_eff - LW_CMP_W'(1);
      last_line = lines_eff - FL_CMP_W'(1);
   end

   assign line_end  = {{(LW_CMP_W-LW_CW){1'b0}}, col_cnt_ff} >= last_col;
   assign frame_end = line_end && ({{(FL_CMP_W-FL_CW){1'b0}}, line_cnt_ff} >= last_line);

   always_comb begin
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      line_width_in  = line_width_ff;
      frame_lines_in = frame_lines_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_X:      step_x_in      = csr_wdata[STEP_W-1:0];
            CSR_STEP_Y:      step_y_in      = csr_wdata[STEP_W-1:0];
            CSR_LINE_WIDTH:  line_width_in  = csr_wdata[DIM_W-1:0];
            CSR_FRAME_LINES: frame_lines_in = csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      acc_u_in    = acc_u_ff;
      acc_v_in    = acc_v_ff;
      start_u_in  = start_u_ff;
      start_v_in  = start_v_ff;
      col_cnt_in  = col_cnt_ff;
      line_cnt_in = line_cnt_ff;
      if (tick) begin
         if (frame_end) begin
            acc_u_in    = '0;
            acc_v_in    = '0;
            start_u_in  = '0;
            start_v_in  = '0;
            col_cnt_in  = '0;
            line_cnt_in = '0;
         end else if (line_end) begin
            // next line starts perpendicular to the step vector
            start_u_in  = start_u_ff - sy_ext;
            start_v_in  = start_v_ff + sx_ext;
            acc_u_in    = start_u_ff - sy_ext;
            acc_v_in    = start_v_ff + sx_ext;
            col_cnt_in  = '0;
            line_cnt_in = line_cnt_ff + FL_CW'(1);
         end else begin
            acc_u_in    = sum_u;
            acc_v_in    = sum_v;
            col_cnt_in  = col_cnt_ff + LW_CW'(1);
         end
      end
   end

   always_comb begin
      q_push = accept;
      q_entry.is_pixel = (in_mode == MODE_PIXEL);
      if (in_mode == MODE_PIXEL) begin
         q_entry.addr      = {row, col};
         q_entry.color     = in_color;
         q_entry.line_end  = line_end;
         q_entry.frame_end = frame_end;
      end else begin
         q_entry.addr      = in_addr;
         q_entry.color     = in_color;
         q_entry.line_end  = 1'b0;
         q_entry.frame_end = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff      <= STEP_X_RESET;
         step_y_ff      <= STEP_Y_RESET;
         line_width_ff  <= LINE_WIDTH_RESET;
         frame_lines_ff <= FRAME_LINES_RESET;
         acc_u_ff       <= '0;
         acc_v_ff       <= '0;
         start_u_ff     <= '0;
         start_v_ff     <= '0;
         col_cnt_ff     <= '0;
         line_cnt_ff    <= '0;
      end else begin
         step_x_ff      <= step_x_in;
         step_y_ff      <= step_y_in;
         line_width_ff  <= line_width_in;
         frame_lines_ff <= frame_lines_in;
         acc_u_ff       <= acc_u_in;
         acc_v_ff       <= acc_v_in;
         start_u_ff     <= start_u_in;
         start_v_ff     <= start_v_in;
         col_cnt_ff     <= col_cnt_in;
         line_cnt_ff    <= line_cnt_in;
      end
   end

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      tick && frame_end |=> acc_u_ff == '0 && acc_v_ff == '0 && col_cnt_ff == '0
                            && line_cnt_ff == '0)
      else $error("raster state not cleared after frame end");

   a_frame_end_is_line_end: assert property (@(posedge clock) disable iff (reset)
      q_push && q_entry.frame_end |-> q_entry.line_end && q_entry.is_pixel)
      else $error("frame end queued without line end");

endmodule

### hw/rtl/atr_queue.sv
// Short FIFO of operations between the front end and the texture back end.
module atr_queue import atr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head,
   output logic            empty,
   output logic            full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   queue_entry_type  slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue overflow");

endmodule

### hw/rtl/atr_back.sv
// Back end: texture store, registered lookup and result output register.
module atr_back import atr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  queue_entry_type          q_head,
   output logic                     q_pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [COLOR_W-1:0]       out_color,
   output logic [TEX_SIDE_BITS-1:0] out_column,
   output logic [TEX_SIDE_BITS-1:0] out_row,
   output logic                     out_line_end,
   output logic                     out_frame_end
);

   localparam int STORE_DEPTH = 1 << ADDR_W;

   logic [COLOR_W-1:0] texture_mem [STORE_DEPTH];

   logic [COLOR_W-1:0]       rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr_ff;
   logic                     rd_lend_ff, rd_fend_ff;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     out_vld_ff, out_vld_in;
   logic [COLOR_W-1:0]       out_color_ff;
   logic [ADDR_W-1:0]        out_addr_ff;
   logic                     out_lend_ff, out_fend_ff;
   logic                     s1_move, s1_free, rd_issue, wr_issue;

   assign s1_move  = rd_vld_ff && (!out_vld_ff || out_ready);
   assign s1_free  = !rd_vld_ff || s1_move;
   // writes never wait; a lookup waits for room in the read stage
   assign q_pop    = !q_empty && (!q_head.is_pixel || s1_free);
   assign rd_issue = q_pop && q_head.is_pixel;
   assign wr_issue = q_pop && !q_head.is_pixel;

   always_comb begin
      rd_vld_in  = rd_issue ? 1'b1 : (s1_move ? 1'b0 : rd_vld_ff);
      out_vld_in = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_issue) begin
         texture_mem[q_head.addr] <= q_head.color;
      end
      if (rd_issue) begin
         rd_data_ff <= texture_mem[q_head.addr];
         rd_addr_ff <= q_head.addr;
         rd_lend_ff <= q_head.line_end;
         rd_fend_ff <= q_head.frame_end;
      end
      if (s1_move) begin
         out_color_ff <= rd_data_ff;
         out_addr_ff  <= rd_addr_ff;
         out_lend_ff  <= rd_lend_ff;
         out_fend_ff  <= rd_fend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign out_valid     = out_vld_ff;
   assign out_color     = out_color_ff;
   assign out_column    = out_addr_ff[TEX_SIDE_BITS-1:0];
   assign out_row       = out_addr_ff[ADDR_W-1:TEX_SIDE_BITS];
   assign out_line_end  = out_lend_ff;
   assign out_frame_end = out_fend_ff;

   a_read_stage_holds: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff && out_vld_ff && !out_ready |=> rd_vld_ff && $stable(rd_data_ff)
                                                && $stable(rd_addr_ff))
      else $error("stalled lookup overwritten");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule

### hw/rtl/affine_texture_rotozoom.sv
// Rotozoom texture mapper: 256x256 RGB store sampled along a stepped affine raster.
// Throughput: one item per clock on either kind while the queue is not full; texel writes
//   give no result. A pixel tick passes through the queue, the texture RAM read register
//   and the output register, which drives rsp_tvalid.
// Rate is set by the single-port texture RAM taking one write or one read a cycle.
// Reset: synchronous; clears queue, pipeline valids, accumulators and counters and
//   loads the register defaults. The texture store is not cleared and holds garbage.
module affine_texture_rotozoom import atr_pkg::*; #(
   parameter int MAX_LINE_WIDTH  = 1024,
   parameter int MAX_FRAME_LINES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,  // texel_address[15:0], texel_color[39:16]
   input  logic                  req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,  // pixel_color[23:0], tex_column[31:24],
                                             // tex_row[39:32]
   output logic                  rsp_tlast,  // line_end
   output logic                  rsp_tuser   // frame_end
);

   queue_entry_type push_entry, head;
   logic            push, pop, q_empty, q_full;
   logic [COLOR_W-1:0]       pix_color;
   logic [TEX_SIDE_BITS-1:0] pix_col, pix_row;

   atr_front #(
      .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
      .MAX_FRAME_LINES (MAX_FRAME_LINES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mode   (req_tuser),
      .in_addr   (req_tdata[ADDR_W-1:0]),
      .in_color  (req_tdata[ADDR_W+COLOR_W-1:ADDR_W]),
      .q_full    (q_full),
      .q_push    (push),
      .q_entry   (push_entry)
   );

   atr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   atr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (head),
      .q_pop         (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_color     (pix_color),
      .out_column    (pix_col),
      .out_row       (pix_row),
      .out_line_end  (rsp_tlast),
      .out_frame_end (rsp_tuser)
   );

   assign rsp_tdata = {pix_row, pix_col, pix_color};

endmodule

### dv/testbench.sv
// Self-checking testbench for the affine rotozoom texture mapper.
module testbench;
   import atr_pkg::*;

   localparam int ITEMS   = 1450;
   localparam int MAX_DIM = 1024;
   localparam int SETTLE  = 8;

   typedef struct packed {
      logic [COLOR_W-1:0]       color;
      logic [TEX_SIDE_BITS-1:0] col;
      logic [TEX_SIDE_BITS-1:0] row;
      logic                     line_end;
      logic                     frame_end;
   } pixel_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [ADDR_W-1:0]   addr;   // register index on CSR rows
      logic [COLOR_W-1:0]  data;
      logic                typed;
      pixel_type           want;
   } stim_row_type;

   localparam pixel_type NO_PIXEL = '0;

   localparam stim_row_type DIRECTED [28] = '{
      '{ROW_WRITE, 16'h0000, 24'hFFFFFF, 1'b0, NO_PIXEL},
      '{ROW_WRITE, 16'hFFFF, 24'h000000, 1'b0, NO_PIXEL},
      // first pixel after reset with the default step
      '{ROW_TICK, 16'h0000, 24'h0, 1'b1, '{24'hFFFFFF, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b0, NO_PIXEL},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_STEP_X), 24'h1FFFF, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_STEP_Y), 24'h20000, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_LINE_WIDTH), 24'd1, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_FRAME_LINES), 24'd1, 1'b0, NO_PIXEL},
      // width shrunk below the current column: line and frame end at once
      '{ROW_TICK, 16'h0000, 24'h0, 1'b0, NO_PIXEL},
      '{ROW_WRITE, 16'hFF00, 24'h00FF00, 1'b0, NO_PIXEL},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b1, '{24'h00FF00, 8'd0, 8'd255, 1'b1, 1'b1}},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b1, '{24'h00FF00, 8'd0, 8'd255, 1'b1, 1'b1}},
      '{ROW_CSR, 16'(CSR_STEP_X), 24'h20000, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_STEP_Y), 24'h1FFFF, 1'b0, NO_PIXEL},
      // zero sizes behave as one
      '{ROW_CSR, 16'(CSR_LINE_WIDTH), 24'd0, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_FRAME_LINES), 24'd0, 1'b0, NO_PIXEL},
      '{ROW_WRITE, 16'h00FF, 24'h0F0F0F, 1'b0, NO_PIXEL},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b1, '{24'h0F0F0F, 8'd255, 8'd0, 1'b1, 1'b1}},
      // oversized dimensions saturate
      '{ROW_CSR, 16'(CSR_LINE_WIDTH), 24'd2047, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_FRAME_LINES), 24'd2047, 1'b0, NO_PIXEL},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b0, NO_PIXEL},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_LINE_WIDTH), 24'd2, 1'b0, NO_PIXEL},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b0, NO_PIXEL},
      '{ROW_CSR, 16'(CSR_FRAME_LINES), 24'd1, 1'b0, NO_PIXEL},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b0, NO_PIXEL},
      '{ROW_TICK, 16'h0000, 24'h0, 1'b0, NO_PIXEL}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;  // texel_address[15:0], texel_color[39:16]
   logic                  req_tuser = 1'b0;  // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [39:0]           rsp_tdata;  // pixel_color[23:0], tex_column[31:24], tex_row[39:32]
   logic                  rsp_tlast;  // line_end
   logic                  rsp_tuser;  // frame_end

   affine_texture_rotozoom u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mapper state as seen by the predictor
   logic [COLOR_W-1:0] texels  [1 << ADDR_W];
   bit                 written [1 << ADDR_W];
   logic [STEP_W-1:0]  step_x = STEP_X_RESET;
   logic [STEP_W-1:0]  step_y = STEP_Y_RESET;
   logic [DIM_W-1:0]   line_width = LINE_WIDTH_RESET;
   logic [DIM_W-1:0]   frame_lines = FRAME_LINES_RESET;
   logic [ACC_W-1:0]   acc_u = '0, acc_v = '0, start_u = '0, start_v = '0;
   int                 pixel_column = 0, pixel_line = 0;

   pixel_type pending_pixels [$];
   int        errors = 0;
   int        items_sent = 0;
   int        idle_odds = 4;
   bit        calm = 1'b0;
   int        stall_left = 0;

   function automatic logic [ACC_W-1:0] widen_step(logic [STEP_W-1:0] s);
      return {{(ACC_W-STEP_W){s[STEP_W-1]}}, s};
   endfunction

   function automatic int clamp_dim(logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   // texel the next pixel tick will sample
   function automatic logic [ADDR_W-1:0] next_texel();
      logic [ACC_W-1:0] u, v;
      u = acc_u + widen_step(step_x);
      v = acc_v + widen_step(step_y);
      return {v[ACC_W-1:FRAC_BITS], u[ACC_W-1:FRAC_BITS]};
   endfunction

   function automatic pixel_type rotozoom_tick();
      pixel_type px;
      int        width, lines;
      acc_u = acc_u + widen_step(step_x);
      acc_v = acc_v + widen_step(step_y);
      width = clamp_dim(line_width);
      lines = clamp_dim(frame_lines);
      px.col       = acc_u[ACC_W-1:FRAC_BITS];
      px.row       = acc_v[ACC_W-1:FRAC_BITS];
      px.color     = texels[{px.row, px.col}];
      px.line_end  = (pixel_column >= width - 1);
      px.frame_end = px.line_end && (pixel_line >= lines - 1);
      if (px.frame_end) begin
         acc_u = '0; acc_v = '0; start_u = '0; start_v = '0;
         pixel_column = 0;
         pixel_line = 0;
      end else if (px.line_end) begin
         // next line starts perpendicular to the step vector
         start_u = start_u - widen_step(step_y);
         start_v = start_v + widen_step(step_x);
         acc_u = start_u;
         acc_v = start_v;
         pixel_column = 0;
         pixel_line++;
      end else begin
         pixel_column++;
      end
      return px;
   endfunction

   task automatic push_item(logic mode, logic [ADDR_W-1:0] addr, logic [COLOR_W-1:0] color,
                            bit typed, pixel_type want);
      pixel_type px;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {color, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (mode == MODE_WRITE) begin
         texels[addr]  = color;
         written[addr] = 1'b1;
      end else begin
         px = rotozoom_tick();
         pending_pixels.push_back(typed ? want : px);
      end
      if (items_sent > ITEMS - 200) calm = 1'b1;
      if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // a tick never samples a texel that has not been loaded
   task automatic pixel_tick(bit typed, pixel_type want);
      logic [ADDR_W-1:0] a;
      a = next_texel();
      if (!written[a]) push_item(MODE_WRITE, a, COLOR_W'($urandom), 1'b0, NO_PIXEL);
      push_item(MODE_PIXEL, ADDR_W'($urandom), COLOR_W'($urandom), typed, want);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_STEP_X:      step_x = val;
         CSR_STEP_Y:      step_y = val;
         CSR_LINE_WIDTH:  line_width = val[DIM_W-1:0];
         CSR_FRAME_LINES: frame_lines = val[DIM_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [DIM_W-1:0] pick_dim(int typical);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return DIM_W'(2047);
         2: return DIM_W'(MAX_DIM);
         3: return DIM_W'(1);
         default: return DIM_W'($urandom_range(1, typical));
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(0, 7))
         0: return STEP_W'(18'h1FFFF);
         1: return STEP_W'(18'h20000);
         default: return STEP_W'($urandom);
      endcase
   endfunction

   // output side: random back-pressure and result checking
   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_tready <= 1'b1;
      end else if (!reset && !calm && idle_odds != 0 &&
                   $urandom_range(1, 3 * idle_odds) == 1) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 16);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[23:0], rsp_tdata[31:24], rsp_tdata[39:32], rsp_tlast, rsp_tuser};
         if (pending_pixels.size() == 0) begin
            $display("%0t: pixel with none expected: %h", $time, got);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (got.color !== want.color) begin
               $display("%0t: pixel_color expected %h got %h", $time, want.color, got.color);
               errors++;
            end
            if (got.col !== want.col) begin
               $display("%0t: tex_column expected %0d got %0d", $time, want.col, got.col);
               errors++;
            end
            if (got.row !== want.row) begin
               $display("%0t: tex_row expected %0d got %0d", $time, want.row, got.row);
               errors++;
            end
            if (got.line_end !== want.line_end) begin
               $display("%0t: line_end expected %b got %b", $time, want.line_end,
                        got.line_end);
               errors++;
            end
            if (got.frame_end !== want.frame_end) begin
               $display("%0t: frame_end expected %b got %b", $time, want.frame_end,
                        got.frame_end);
               errors++;
            end
         end
      end
   end

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         case (DIRECTED[i].kind)
            ROW_WRITE: push_item(MODE_WRITE, DIRECTED[i].addr, DIRECTED[i].data, 1'b0, NO_PIXEL);
            ROW_TICK:  pixel_tick(DIRECTED[i].typed, DIRECTED[i].want);
            ROW_CSR: begin
               settle();
               csr_write(csr_index_type'(DIRECTED[i].addr[CSR_IDX_W-1:0]),
                         DIRECTED[i].data[CSR_DATA_W-1:0]);
            end
            default: ;
         endcase
      end

      // random phases, each starting from an idle block with fresh registers
      while (items_sent < ITEMS) begin
         settle();
         idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
         csr_write(CSR_STEP_X, pick_step());
         csr_write(CSR_STEP_Y, pick_step());
         csr_write(CSR_LINE_WIDTH, CSR_DATA_W'(pick_dim(8)));
         csr_write(CSR_FRAME_LINES, CSR_DATA_W'(pick_dim(6)));
         n = 0;
         while (n < 100 && items_sent < ITEMS) begin
            if ($urandom_range(0, 9) < 3)
               push_item(MODE_WRITE, ADDR_W'($urandom), COLOR_W'($urandom), 1'b0, NO_PIXEL);
            else
               pixel_tick(1'b0, NO_PIXEL);
            n++;
         end
      end

      settle();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #(20 * 400_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
hw/rtl/atr_pkg.sv
hw/rtl/atr_front.sv
hw/rtl/atr_queue.sv
hw/rtl/atr_back.sv
hw/rtl/affine_texture_rotozoom.sv
dv/testbench.sv
